>>> rtl/rv32i_integer_execute_unit_assert.svh
// Assertion macros for the integer execute unit.
`ifndef RV32I_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define RV32I_INTEGER_EXECUTE_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define RVX_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error("execute unit check failed");

// Check that a condition implies a consequence in the next cycle.
`define RVX_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error("execute unit sequencing check failed");

`endif

>>> rtl/rvx_pkg.sv
// Shared types and constants for the integer execute unit.
`timescale 1ns / 1ps

package rvx_pkg;

    localparam int XLEN       = 32;
    localparam int SHAMT_W    = 5;
    localparam int BYTES_W    = 3;
    localparam int UPPER_SHIFT = 12;

    localparam logic [XLEN-1:0]    LINK_STEP  = 32'd4;
    localparam logic [BYTES_W-1:0] WORD_BYTES = 3'd4;

    typedef enum logic [4:0] {
        OP_BEQ   = 5'd0,
        OP_BNE   = 5'd1,
        OP_BLT   = 5'd2,
        OP_BGE   = 5'd3,
        OP_BLTU  = 5'd4,
        OP_BGEU  = 5'd5,
        OP_JALR  = 5'd6,
        OP_JAL   = 5'd7,
        OP_LUI   = 5'd8,
        OP_AUIPC = 5'd9,
        OP_ADDI  = 5'd10,
        OP_SLLI  = 5'd11,
        OP_SLTI  = 5'd12,
        OP_SLTIU = 5'd13,
        OP_XORI  = 5'd14,
        OP_SRLI  = 5'd15,
        OP_SRAI  = 5'd16,
        OP_ORI   = 5'd17,
        OP_ANDI  = 5'd18,
        OP_ADD   = 5'd19,
        OP_SUB   = 5'd20,
        OP_SLL   = 5'd21,
        OP_SLT   = 5'd22,
        OP_SLTU  = 5'd23,
        OP_XOR   = 5'd24,
        OP_SRL   = 5'd25,
        OP_SRA   = 5'd26,
        OP_OR    = 5'd27,
        OP_AND   = 5'd28,
        OP_LW    = 5'd29,
        OP_SW    = 5'd30
    } t_op;

    typedef struct packed {
        logic            taken;
        logic [XLEN-1:0] next_pc;
    } t_redirect;

endpackage

>>> rtl/rvx_alu.sv
// Destination value logic: ALU ops, upper immediates and link address.
`timescale 1ns / 1ps

module rvx_alu
    import rvx_pkg::*;
(
    input  t_op             i_op,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_src1,
    input  logic [XLEN-1:0] i_src2,
    input  logic [XLEN-1:0] i_imm,
    output logic [XLEN-1:0] o_dst_value,
    output logic            o_dst_write
);

    logic [XLEN-1:0]    opb;
    logic [SHAMT_W-1:0] shamt;
    logic [XLEN-1:0]    upper;

    // register-immediate ops take imm, everything else takes src2
    assign opb   = (i_op inside {[OP_ADDI:OP_ANDI]}) ? i_imm : i_src2;
    assign shamt = opb[SHAMT_W-1:0];
    assign upper = i_imm << UPPER_SHIFT;

    always_comb begin
        o_dst_write = 1'b1;
        case (i_op)
            OP_JALR, OP_JAL:   o_dst_value = i_pc + LINK_STEP;
            OP_LUI:            o_dst_value = upper;
            OP_AUIPC:          o_dst_value = i_pc + upper;
            OP_ADDI, OP_ADD:   o_dst_value = i_src1 + opb;
            OP_SUB:            o_dst_value = i_src1 - opb;
            OP_SLLI, OP_SLL:   o_dst_value = i_src1 << shamt;
            OP_SLTI, OP_SLT:   o_dst_value = {{(XLEN-1){1'b0}},
                                              $signed(i_src1) < $signed(opb)};
            OP_SLTIU, OP_SLTU: o_dst_value = {{(XLEN-1){1'b0}}, i_src1 < opb};
            OP_XORI, OP_XOR:   o_dst_value = i_src1 ^ opb;
            OP_SRLI, OP_SRL:   o_dst_value = i_src1 >> shamt;
            OP_SRAI, OP_SRA:   o_dst_value = XLEN'($signed(i_src1) >>> shamt);
            OP_ORI, OP_OR:     o_dst_value = i_src1 | opb;
            OP_ANDI, OP_AND:   o_dst_value = i_src1 & opb;
            default: begin
                // branches, loads, stores and the unused code write nothing
                o_dst_value = '0;
                o_dst_write = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rvx_branch.sv
// Branch compare and jump target logic.
`timescale 1ns / 1ps

module rvx_branch
    import rvx_pkg::*;
(
    input  t_op             i_op,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_src1,
    input  logic [XLEN-1:0] i_src2,
    input  logic [XLEN-1:0] i_imm,
    output t_redirect       o_redirect
);

    logic            eq;
    logic            lt_s;
    logic            lt_u;
    logic [XLEN-1:0] rel_target;
    logic [XLEN-1:0] reg_target;

    assign eq         = (i_src1 == i_src2);
    assign lt_s       = ($signed(i_src1) < $signed(i_src2));
    assign lt_u       = (i_src1 < i_src2);
    assign rel_target = i_pc + i_imm;
    assign reg_target = i_src1 + i_imm;

    always_comb begin
        o_redirect.taken   = 1'b0;
        o_redirect.next_pc = i_pc;
        case (i_op)
            OP_BEQ:  o_redirect.taken = eq;
            OP_BNE:  o_redirect.taken = !eq;
            OP_BLT:  o_redirect.taken = lt_s;
            OP_BGE:  o_redirect.taken = !lt_s;
            OP_BLTU: o_redirect.taken = lt_u;
            OP_BGEU: o_redirect.taken = !lt_u;
            OP_JAL:  o_redirect.taken = 1'b1;
            OP_JALR: o_redirect.taken = 1'b1;
            default: o_redirect.taken = 1'b0;
        endcase
        if (o_redirect.taken) begin
            // jalr drops bit 0 of its register-relative target
            o_redirect.next_pc = (i_op == OP_JALR) ? {reg_target[XLEN-1:1], 1'b0}
                                                   : rel_target;
        end
    end

endmodule

>>> rtl/rv32i_integer_execute_unit.sv
// Top level of the RV32I integer execute unit.
`timescale 1ns / 1ps
//
// Execute stage for the RV32I integer subset: branches, jal, jalr, lui,
// auipc, register-immediate and register-register ALU ops, and lw/sw
// address generation.
//
// Input channel: drive i_req_type, i_pc, i_src1, i_src2 and i_imm and raise
// start. An item is taken at every rising edge where start is high and busy
// is low. busy stays low: the unit takes one item in every cycle.
//
// Result channel: one result per item. o_valid is high for exactly one cycle
// while the result fields hold it; the receiver must take it then, since it
// cannot stall the unit.
//
// Path: an item is held in one input register, passes short decode/ALU/compare
// logic and is held in one result register. Throughput: one item per cycle, set
// by the combinational ALU and branch path between the two registers.
//
// Reset (i_rst_n low, synchronous): clear both valid flags; no result is
// shown until a new item arrives.

`include "rv32i_integer_execute_unit_assert.svh"

module rv32i_integer_execute_unit
    import rvx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         i_req_type,
    input  logic [XLEN-1:0]    i_pc,
    input  logic [XLEN-1:0]    i_src1,
    input  logic [XLEN-1:0]    i_src2,
    input  logic [XLEN-1:0]    i_imm,
    output logic               o_valid,
    output logic [XLEN-1:0]    o_dst_value,
    output logic               o_dst_write,
    output logic               o_taken,
    output logic [XLEN-1:0]    o_next_pc,
    output logic [XLEN-1:0]    o_mem_address,
    output logic [XLEN-1:0]    o_store_value,
    output logic               o_mem_read,
    output logic               o_mem_write,
    output logic [BYTES_W-1:0] o_access_bytes
);

    // input register stage
    logic            r_in_valid;
    t_op             r_op;
    logic [XLEN-1:0] r_pc;
    logic [XLEN-1:0] r_src1;
    logic [XLEN-1:0] r_src2;
    logic [XLEN-1:0] r_imm;

    // result register stage
    logic               r_out_valid;
    logic [XLEN-1:0]    r_dst_value;
    logic               r_dst_write;
    t_redirect          r_redirect;
    logic [XLEN-1:0]    r_mem_address;
    logic [XLEN-1:0]    r_store_value;
    logic               r_mem_read;
    logic               r_mem_write;
    logic [BYTES_W-1:0] r_access_bytes;

    // next values for the result register
    logic [XLEN-1:0]    n_dst_value;
    logic               n_dst_write;
    t_redirect          n_redirect;
    logic [XLEN-1:0]    n_mem_address;
    logic [XLEN-1:0]    n_store_value;
    logic               n_mem_read;
    logic               n_mem_write;
    logic [BYTES_W-1:0] n_access_bytes;

    logic accept;

    // Never stall: both stages advance every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the item; the valid flag marks a live entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_req_type);
            r_pc   <= i_pc;
            r_src1 <= i_src1;
            r_src2 <= i_src2;
            r_imm  <= i_imm;
        end
    end

    rvx_alu u_alu (
        .i_op        (r_op),
        .i_pc        (r_pc),
        .i_src1      (r_src1),
        .i_src2      (r_src2),
        .i_imm       (r_imm),
        .o_dst_value (n_dst_value),
        .o_dst_write (n_dst_write)
    );

    rvx_branch u_branch (
        .i_op       (r_op),
        .i_pc       (r_pc),
        .i_src1     (r_src1),
        .i_src2     (r_src2),
        .i_imm      (r_imm),
        .o_redirect (n_redirect)
    );

    // Load/store side: address, store data and access flags.
    always_comb begin
        n_mem_address  = '0;
        n_store_value  = '0;
        n_mem_read     = 1'b0;
        n_mem_write    = 1'b0;
        n_access_bytes = '0;
        case (r_op)
            OP_LW: begin
                n_mem_address  = r_src1 + r_imm;
                n_mem_read     = 1'b1;
                n_access_bytes = WORD_BYTES;
            end
            OP_SW: begin
                n_mem_address  = r_src1 + r_imm;
                n_store_value  = r_src2;
                n_mem_write    = 1'b1;
                n_access_bytes = WORD_BYTES;
            end
            default: begin
                n_mem_read = 1'b0;
            end
        endcase
    end

    // Result register: the strobe follows the input stage's valid flag in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_dst_value    <= n_dst_value;
            r_dst_write    <= n_dst_write;
            r_redirect     <= n_redirect;
            r_mem_address  <= n_mem_address;
            r_store_value  <= n_store_value;
            r_mem_read     <= n_mem_read;
            r_mem_write    <= n_mem_write;
            r_access_bytes <= n_access_bytes;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_dst_value    = r_dst_value;
    assign o_dst_write    = r_dst_write;
    assign o_taken        = r_redirect.taken;
    assign o_next_pc      = r_redirect.next_pc;
    assign o_mem_address  = r_mem_address;
    assign o_store_value  = r_store_value;
    assign o_mem_read     = r_mem_read;
    assign o_mem_write    = r_mem_write;
    assign o_access_bytes = r_access_bytes;

    // Every accepted item reaches the result register in the following cycle.
    `RVX_ASSERT_NEXT(a_item_advances, r_in_valid, o_valid)
    // Loads and stores are exclusive.
    `RVX_ASSERT_SAME(a_mem_exclusive, o_valid, !(o_mem_read && o_mem_write))
    // An access size is reported exactly for memory ops.
    `RVX_ASSERT_SAME(a_bytes_match, o_valid,
                     (o_access_bytes != '0) == (o_mem_read || o_mem_write))
    // Nothing is written back by a memory op, and no write means zero value.
    `RVX_ASSERT_SAME(a_no_write_zero, o_valid && !o_dst_write, o_dst_value == '0)

endmodule
